// ----- hdl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  // Signed search bound: holds -1 up to TABLE_DEPTH.
  localparam int PTR_W       = CNT_W + 1;
  localparam int VAL_W       = 32;

  localparam int IN_TDATA_W  = 8 * ((IDX_W + 2 * VAL_W + 7) / 8);
  localparam int OUT_TDATA_W = 8 * ((IDX_W + 7) / 8);

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Operation codes carried in the input tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register indexes (paddr[2]).
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Table read request from the search sequencer.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

endpackage

`default_nettype wire

// ----- hdl/sorted_table_binary_search.sv -----
// Order: a write lands in the table at its transfer edge. A search steps through
//   S_PROBE then S_CMP for each probe (at most 9 probes over 256 entries, each a
//   table read plus compare) and then S_DONE, which loads the output register.
// Flow: a search holds off input until its result is loaded into the output
//   register; writes are taken every cycle while idle.
// Reset (rst, synchronous): clears sequencer, output valid and entry_count, not the table.
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed values with write items and iterative binary search items.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Input stream.
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // tdata: entry_index [7:0], entry_value [39:8], search_key [71:40]
  input  wire logic [stbs_pkg::IN_TDATA_W-1:0]      s_tdata,
  // tuser: operation
  input  wire logic                                 s_tuser,
  // Output stream.
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // tdata: found_index [7:0]
  output logic      [stbs_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // tuser: found
  output logic                                      m_tuser,
  // Configuration port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [stbs_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [stbs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [stbs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready
);

  logic [stbs_pkg::CNT_W-1:0]  entry_count;
  logic                        s_xfer;
  logic                        busy;
  logic [stbs_pkg::IDX_W-1:0]  in_index;
  logic [stbs_pkg::VAL_W-1:0]  in_value;
  logic [stbs_pkg::VAL_W-1:0]  in_key;
  logic                        wr_en;
  stbs_pkg::tbl_rd_t           rd;
  logic [stbs_pkg::VAL_W-1:0]  rd_data;
  logic [stbs_pkg::IDX_W-1:0]  res_index;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == stbs_pkg::REG_ENTRY_COUNT)) begin
      entry_count <= pwdata[stbs_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == stbs_pkg::REG_ENTRY_COUNT)
                  ? stbs_pkg::APB_DATA_W'(entry_count) : '0;

  assign in_index = s_tdata[stbs_pkg::IDX_W-1:0];
  assign in_value = s_tdata[stbs_pkg::IDX_W +: stbs_pkg::VAL_W];
  assign in_key   = s_tdata[stbs_pkg::IDX_W + stbs_pkg::VAL_W +: stbs_pkg::VAL_W];

  assign s_tready = !busy;
  assign s_xfer   = s_tvalid && s_tready;
  assign wr_en    = s_xfer && (s_tuser == stbs_pkg::OP_WRITE);

  stbs_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_index),
    .wr_data (in_value),
    .rd      (rd),
    .rd_data (rd_data)
  );

  stbs_search u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (s_xfer && (s_tuser == stbs_pkg::OP_SEARCH)),
    .key_in      (in_key),
    .entry_count (entry_count),
    .rd          (rd),
    .rd_data     (rd_data),
    .busy        (busy),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res_found   (m_tuser),
    .res_index   (res_index)
  );

  assign m_tdata = stbs_pkg::OUT_TDATA_W'(res_index);

  // A search transfer occupies the block in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_xfer && (s_tuser == stbs_pkg::OP_SEARCH)) |=> !s_tready)
    else $error("search did not make the block busy");

  // A miss always reports index zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("miss with nonzero index");

  // Probes never leave the range in use.
  assert property (@(posedge clk) disable iff (rst)
    rd.en |-> ({1'b0, rd.addr} < entry_count))
    else $error("probe outside the entries in use");

  // A hit lies inside the range in use.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> ({1'b0, res_index} < entry_count))
    else $error("hit index outside the entries in use");

endmodule

`default_nettype wire

// ----- hdl/stbs_table.sv -----
// ----------------------------------------------------------------------------
// stbs_table
// Value table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_table (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [stbs_pkg::IDX_W-1:0]      wr_addr,
  input  wire logic [stbs_pkg::VAL_W-1:0]      wr_data,
  input  wire stbs_pkg::tbl_rd_t               rd,
  output logic      [stbs_pkg::VAL_W-1:0]      rd_data
);

  logic [stbs_pkg::VAL_W-1:0] mem [stbs_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stbs_search.sv -----
// ----------------------------------------------------------------------------
// stbs_search
// Binary search sequencer: one shared midpoint adder and one signed compare,
// reused for every probe, plus the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [stbs_pkg::VAL_W-1:0]    key_in,
  input  wire logic [stbs_pkg::CNT_W-1:0]    entry_count,
  output stbs_pkg::tbl_rd_t                  rd,
  input  wire logic [stbs_pkg::VAL_W-1:0]    rd_data,
  output logic                               busy,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic                               res_found,
  output logic      [stbs_pkg::IDX_W-1:0]    res_index
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t                              state;
  logic signed [stbs_pkg::PTR_W-1:0]   left;
  logic signed [stbs_pkg::PTR_W-1:0]   right;
  logic        [stbs_pkg::IDX_W-1:0]   mid;
  logic signed [stbs_pkg::VAL_W-1:0]   key;
  logic                                hit;
  logic        [stbs_pkg::IDX_W-1:0]   hit_index;

  logic        [stbs_pkg::CNT_W-1:0]   count_sat;
  logic signed [stbs_pkg::PTR_W-1:0]   span;
  logic signed [stbs_pkg::PTR_W-1:0]   mid_calc;
  logic signed [stbs_pkg::PTR_W-1:0]   mid_ext;
  logic                                in_range;
  logic signed [stbs_pkg::VAL_W-1:0]   probe_val;

  assign count_sat = (entry_count > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH))
                     ? stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : entry_count;

  // The span is never negative while the range is open, so a shift halves it.
  assign span      = right - left;
  assign mid_calc  = left + (span >>> 1);
  assign in_range  = (left <= right);
  assign mid_ext   = $signed({{(stbs_pkg::PTR_W - stbs_pkg::IDX_W){1'b0}}, mid});
  assign probe_val = $signed(rd_data);

  assign rd.en   = (state == S_PROBE) && in_range;
  assign rd.addr = mid_calc[stbs_pkg::IDX_W-1:0];
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (res_valid && res_ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            key   <= $signed(key_in);
            left  <= '0;
            right <= $signed({1'b0, count_sat}) - stbs_pkg::PTR_W'(1);
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (in_range) begin
            mid   <= mid_calc[stbs_pkg::IDX_W-1:0];
            state <= S_CMP;
          end else begin
            hit   <= 1'b0;
            state <= S_DONE;
          end
        end
        S_CMP: begin
          if (probe_val == key) begin
            hit       <= 1'b1;
            hit_index <= mid;
            state     <= S_DONE;
          end else begin
            if (probe_val < key) begin
              left <= mid_ext + stbs_pkg::PTR_W'(1);
            end else begin
              right <= mid_ext - stbs_pkg::PTR_W'(1);
            end
            state <= S_PROBE;
          end
        end
        S_DONE: begin
          // Wait until the output register is free or being emptied.
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_found <= hit;
            res_index <= hit ? hit_index : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the sorted table binary search block. Table writes and
// key searches go in as input transfers. The entry count is set through the
// APB port before each round. A scoreboard keeps its own copy of the table and
// the count, works out each search result, and compares every output transfer
// field by field. Both stream sides stall at random but for the last phase; the
// run ends on a clean drain or on a stall watchdog.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT    = 4000;
  // Quiet time before a register write; covers the longest search latency.
  localparam int QUIET_CYCLES  = 25;
  localparam int ITEMS_PER_PHASE = 333;
  localparam int REPORT_CAP    = 40;

  localparam logic [stbs_pkg::APB_ADDR_W-1:0] ADDR_ENTRY_COUNT =
    {stbs_pkg::REG_ENTRY_COUNT, 2'b00};
  localparam logic [stbs_pkg::APB_ADDR_W-1:0] ADDR_SPARE =
    {~stbs_pkg::REG_ENTRY_COUNT, 2'b00};

  localparam logic signed [stbs_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [stbs_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    bit                         hit;
    logic [stbs_pkg::IDX_W-1:0] at;
  } search_result_t;

  class search_scoreboard;
    logic signed [stbs_pkg::VAL_W-1:0] cells [stbs_pkg::TABLE_DEPTH];
    bit                                written [stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::CNT_W-1:0]        entry_count;
    search_result_t                    pending_results [$];
    int                                errors;
    int                                hits;
    int                                misses;

    function new();
      foreach (cells[i]) begin
        cells[i] = '0;
        written[i] = 1'b0;
      end
      entry_count = '0;
      errors = 0;
      hits = 0;
      misses = 0;
    endfunction

    function void write_reg(logic [stbs_pkg::APB_ADDR_W-1:0] addr,
                            logic [stbs_pkg::APB_DATA_W-1:0] data);
      if (addr[2] == stbs_pkg::REG_ENTRY_COUNT) entry_count = data[stbs_pkg::CNT_W-1:0];
    endfunction

    // Iterative search over the first entry_count entries. clean drops to 0
    // if any probe lands on an entry that was never written.
    function void predict_search(input logic signed [stbs_pkg::VAL_W-1:0] key,
                                 output search_result_t res, output bit clean);
      int lo;
      int hi;
      int mid;
      bit done;
      lo = 0;
      hi = (entry_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH - 1
                                                 : int'(entry_count) - 1;
      res.hit = 1'b0;
      res.at = '0;
      clean = 1'b1;
      done = 1'b0;
      while (!done && lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (!written[mid]) clean = 1'b0;
        if (cells[mid] == key) begin
          res.hit = 1'b1;
          res.at = stbs_pkg::IDX_W'(mid);
          done = 1'b1;
        end else if (cells[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    endfunction

    function void note_input(logic op, logic [stbs_pkg::IDX_W-1:0] idx,
                             logic signed [stbs_pkg::VAL_W-1:0] val,
                             logic signed [stbs_pkg::VAL_W-1:0] key);
      search_result_t res;
      bit clean;
      if (op == stbs_pkg::OP_WRITE) begin
        cells[idx] = val;
        written[idx] = 1'b1;
      end else begin
        predict_search(key, res, clean);
        if (res.hit) hits++;
        else misses++;
        pending_results.push_back(res);
      end
    endfunction

    function void check_result(logic hit, logic [stbs_pkg::IDX_W-1:0] at);
      search_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual found=%0d index=%0d",
                   $time, hit, at);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: found mismatch, expected %0d, actual %0d", $time, want.hit, hit);
        end
        if (at !== want.at) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: found_index mismatch, expected %0d, actual %0d",
                     $time, want.at, at);
        end
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [stbs_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             s_tuser = stbs_pkg::OP_WRITE;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [stbs_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [stbs_pkg::APB_ADDR_W-1:0]  paddr = '0;
  logic [stbs_pkg::APB_DATA_W-1:0]  pwdata = '0;
  logic [stbs_pkg::APB_DATA_W-1:0]  prdata;
  logic                             pready;

  search_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int writes_sent = 0;
  int searches_sent = 0;
  int skipped_searches = 0;

  sorted_table_binary_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each output transfer, stall at random, and count
  // cycles in which nothing at all is transferred.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[stbs_pkg::IDX_W-1:0]);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: watchdog expired with %0d results outstanding", $time,
             sb.pending_results.size());
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic op, input logic [stbs_pkg::IDX_W-1:0] idx,
                           input logic signed [stbs_pkg::VAL_W-1:0] val,
                           input logic signed [stbs_pkg::VAL_W-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {key, val, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, idx, val, key);
    items_sent++;
    if (op == stbs_pkg::OP_WRITE) writes_sent++;
    else searches_sent++;
  endtask

  task automatic write_entry(input logic [stbs_pkg::IDX_W-1:0] idx,
                             input logic signed [stbs_pkg::VAL_W-1:0] val);
    send_item(stbs_pkg::OP_WRITE, idx, val, $urandom());
  endtask

  // Searches that would probe a never-written entry are left out.
  task automatic search_for(input logic signed [stbs_pkg::VAL_W-1:0] key);
    search_result_t res;
    bit clean;
    sb.predict_search(key, res, clean);
    if (clean) send_item(stbs_pkg::OP_SEARCH, stbs_pkg::IDX_W'($urandom()), $urandom(), key);
    else skipped_searches++;
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [stbs_pkg::APB_ADDR_W-1:0] addr,
                           input logic [stbs_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_entry_count(input int n);
    stop_sending();
    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    apb_write(ADDR_ENTRY_COUNT, n);
  endtask

  // One round: set the count, optionally refill the used entries in
  // ascending order, then mostly searches with a few stray writes.
  task automatic run_round(input int n, input bit refill);
    longint v;
    int used;
    int n_ops;
    logic signed [stbs_pkg::VAL_W-1:0] key;
    used = (n > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : n;
    set_entry_count(n);
    if (refill) begin
      case ($urandom_range(3))
        0: v = VAL_MIN;
        1: v = longint'(VAL_MAX) - 4 * used;
        default: v = longint'($signed($urandom()));
      endcase
      for (int i = 0; i < used; i++) begin
        write_entry(stbs_pkg::IDX_W'(i), v[stbs_pkg::VAL_W-1:0]);
        if ($urandom_range(3) != 0)
          v += ($urandom_range(7) == 0) ? $urandom_range(1, 1 << 24) : $urandom_range(1, 9);
        if (v > longint'(VAL_MAX)) v = VAL_MAX;
      end
    end
    n_ops = $urandom_range(8, 30);
    for (int k = 0; k < n_ops; k++) begin
      if ($urandom_range(9) < 2) begin
        write_entry(stbs_pkg::IDX_W'($urandom()), $urandom());
      end else begin
        if (used == 0 || $urandom_range(3) == 0) key = $urandom();
        else key = sb.cells[$urandom_range(used - 1)];
        if ($urandom_range(3) == 0) key = ($urandom_range(1) == 0) ? key + 1 : key - 1;
        search_for(key);
      end
    end
  endtask

  function automatic int pick_count();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(25, 255);
      2: return 1;
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  initial begin
    int target;
    src_idle_pct = 17;
    sink_idle_pct = 67;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The count is zero after reset, so this is an empty range.
    search_for(0);
    write_entry(0, VAL_MIN);
    write_entry(1, -5);
    write_entry(2, 0);
    write_entry(3, 7);
    write_entry(4, VAL_MAX);
    write_entry(stbs_pkg::IDX_W'(stbs_pkg::TABLE_DEPTH - 1), 32'sh5555_5555);
    set_entry_count(5);
    // An address with no register behind it must leave the count alone.
    apb_write(ADDR_SPARE, '1);
    search_for(VAL_MIN);
    search_for(VAL_MAX);
    search_for(0);
    search_for(7);
    search_for(-5);
    search_for(1);
    search_for(-6);
    search_for(VAL_MAX - 1);
    // Break the ordering: the probe at the middle now decides, so the 7 at
    // index 3 is no longer reachable.
    write_entry(2, 100);
    search_for(100);
    search_for(7);
    set_entry_count(1);
    search_for(VAL_MIN);
    search_for(0);

    // Random part in three idling phases.
    target = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 17; sink_idle_pct = 67; end
        1: begin src_idle_pct = 67; sink_idle_pct = 17; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      target += ITEMS_PER_PHASE;
      if (phase == 2) begin
        run_round(stbs_pkg::TABLE_DEPTH, 1'b1);
        // Count above the table depth saturates; the table is already full.
        run_round((1 << stbs_pkg::CNT_W) - 1, 1'b0);
      end
      while (items_sent < target) run_round(pick_count(), 1'b1);
    end

    stop_sending();
    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.errors++;

    $display("Summary: %0d transfers in (%0d writes, %0d searches), %0d searches skipped",
             items_sent, writes_sent, searches_sent, skipped_searches);
    $display("Summary: %0d keys found, %0d not found, %0d errors",
             sb.hits, sb.misses, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
